@@ sv/q2e_pkg.sv @@
`default_nettype none
package q2e_pkg;

  localparam int unsigned OpW         = 35;  // atan2 operands, units 2^-30
  localparam int unsigned XyW         = 58;  // cordic x/y after scaling by 2^20
  localparam int unsigned AngW        = 33;  // angle, units 2^-30 rad
  localparam int unsigned RemW        = 54;  // root argument shifted by 20
  localparam int unsigned RootW       = 27;
  localparam int unsigned SqrtCells   = 27;
  localparam int unsigned CordicCells = 30;
  // products, sums, root cells, pre-rotation, cordic cells, output register
  localparam int unsigned Latency     = 2 + SqrtCells + 1 + CordicCells + 1;

  localparam logic signed [AngW-1:0] HalfPi   = 33'sd1686629713;
  localparam logic signed [15:0]     RollLim  = 16'sd25736;
  localparam logic signed [15:0]     PitchLim = 16'sd12868;

  typedef struct packed {
    logic signed [XyW-1:0]  x;
    logic signed [XyW-1:0]  y;
    logic signed [AngW-1:0] ang;
    logic                   zero;
  } cordic_lane_t;

  typedef struct packed {
    logic [RemW-1:0] rem;
    logic [RemW-1:0] res;
  } sqrt_lane_t;

  typedef struct packed {
    logic signed [OpW-1:0] sr;
    logic signed [OpW-1:0] cr;
    logic signed [OpW-1:0] sy;
    logic signed [OpW-1:0] cy;
  } rot_ops_t;

  function automatic logic signed [AngW-1:0] atan_tab(input int unsigned i);
    logic signed [AngW-1:0] v;
    case (i)
      0:       v = 33'sd843314857;
      1:       v = 33'sd497837829;
      2:       v = 33'sd263043837;
      3:       v = 33'sd133525159;
      4:       v = 33'sd67021687;
      5:       v = 33'sd33543516;
      6:       v = 33'sd16775851;
      7:       v = 33'sd8388437;
      8:       v = 33'sd4194283;
      9:       v = 33'sd2097149;
      default: v = (i < 30) ? (33'sd1 << (30 - i)) : 33'sd0;
    endcase
    return v;
  endfunction

  // quadrant pre-rotation and scaling of atan2(y, x)
  function automatic cordic_lane_t prerot(input logic signed [OpW-1:0] y,
                                          input logic signed [OpW-1:0] x);
    cordic_lane_t l;
    logic signed [XyW-1:0] xs;
    logic signed [XyW-1:0] ys;
    xs = {{(XyW-OpW-20){x[OpW-1]}}, x, 20'b0};
    ys = {{(XyW-OpW-20){y[OpW-1]}}, y, 20'b0};
    l.zero = (x == '0) && (y == '0);
    if (xs < 0) begin
      if (ys >= 0) begin
        l.x   = ys;
        l.y   = -xs;
        l.ang = HalfPi;
      end else begin
        l.x   = -ys;
        l.y   = xs;
        l.ang = -HalfPi;
      end
    end else begin
      l.x   = xs;
      l.y   = ys;
      l.ang = '0;
    end
    return l;
  endfunction

  function automatic logic signed [15:0] to_q13(input logic signed [35:0] a,
                                                input logic signed [15:0] lim);
    logic signed [35:0] r;
    logic signed [35:0] l;
    r = (a + 36'sd65536) >>> 17;
    l = {{20{lim[15]}}, lim};
    if (r > l) r = l;
    if (r < -l) r = -l;
    return r[15:0];
  endfunction

endpackage
`default_nettype wire

@@ sv/q2e_front.sv @@
`default_nettype none
module q2e_front import q2e_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic signed [15:0] quat_x_i,
  input  wire logic signed [15:0] quat_y_i,
  input  wire logic signed [15:0] quat_z_i,
  input  wire logic signed [15:0] quat_w_i,
  output rot_ops_t                ops_o,
  output sqrt_lane_t              sp_o,
  output sqrt_lane_t              cp_o
);

  localparam logic signed [OpW-1:0] One = 35'sd1 << 30;

  logic signed [31:0] wx_q, yz_q, xx_q, yy_q, wz_q, xy_q, zz_q, wy_q, xz_q;

  always_ff @(posedge clk_i) begin
    wx_q <= quat_w_i * quat_x_i;
    yz_q <= quat_y_i * quat_z_i;
    xx_q <= quat_x_i * quat_x_i;
    yy_q <= quat_y_i * quat_y_i;
    wz_q <= quat_w_i * quat_z_i;
    xy_q <= quat_x_i * quat_y_i;
    zz_q <= quat_z_i * quat_z_i;
    wy_q <= quat_w_i * quat_y_i;
    xz_q <= quat_x_i * quat_z_i;
  end

  function automatic logic signed [OpW-1:0] ext(input logic signed [31:0] v);
    return {{(OpW-32){v[31]}}, v};
  endfunction

  function automatic logic [RemW-1:0] root_arg(input logic signed [OpW-1:0] v);
    // negative argument clamps to zero
    return v[OpW-1] ? '0 : {1'b0, v[32:0], 20'b0};
  endfunction

  logic signed [OpW-1:0] t;
  rot_ops_t ops_d;
  sqrt_lane_t sp_d, cp_d;

  always_comb begin
    t         = ext(wy_q) - ext(xz_q);
    ops_d.sr  = (ext(wx_q) + ext(yz_q)) <<< 1;
    ops_d.cr  = One - ((ext(xx_q) + ext(yy_q)) <<< 1);
    ops_d.sy  = (ext(wz_q) + ext(xy_q)) <<< 1;
    ops_d.cy  = One - ((ext(yy_q) + ext(zz_q)) <<< 1);
    sp_d.rem  = root_arg(One + (t <<< 1));
    sp_d.res  = '0;
    cp_d.rem  = root_arg(One - (t <<< 1));
    cp_d.res  = '0;
  end

  always_ff @(posedge clk_i) begin
    ops_o <= ops_d;
    sp_o  <= sp_d;
    cp_o  <= cp_d;
  end

endmodule
`default_nettype wire

@@ sv/q2e_sqrt_cell.sv @@
`default_nettype none
module q2e_sqrt_cell import q2e_pkg::*; #(
  parameter int unsigned Shift = 0
) (
  input  wire logic  clk_i,
  input  sqrt_lane_t lane_i,
  output sqrt_lane_t lane_o
);

  localparam logic [RemW-1:0] Bit = RemW'(1) << (2 * Shift);

  logic [RemW-1:0] trial;
  sqrt_lane_t lane_d;

  always_comb begin
    trial = lane_i.res + Bit;
    if (lane_i.rem >= trial) begin
      lane_d.rem = lane_i.rem - trial;
      lane_d.res = (lane_i.res >> 1) + Bit;
    end else begin
      lane_d.rem = lane_i.rem;
      lane_d.res = lane_i.res >> 1;
    end
  end

  always_ff @(posedge clk_i) begin
    lane_o <= lane_d;
  end

endmodule
`default_nettype wire

@@ sv/q2e_cordic_cell.sv @@
`default_nettype none
module q2e_cordic_cell import q2e_pkg::*; #(
  parameter int unsigned Iter = 0
) (
  input  wire logic    clk_i,
  input  cordic_lane_t lane_i,
  output cordic_lane_t lane_o
);

  localparam logic signed [AngW-1:0] Step = atan_tab(Iter);

  logic signed [XyW-1:0] dx, dy;
  cordic_lane_t lane_d;

  always_comb begin
    dx = lane_i.y >>> Iter;
    dy = lane_i.x >>> Iter;
    lane_d.zero = lane_i.zero;
    if (lane_i.y > 0) begin
      lane_d.x   = lane_i.x + dx;
      lane_d.y   = lane_i.y - dy;
      lane_d.ang = lane_i.ang + Step;
    end else begin
      lane_d.x   = lane_i.x - dx;
      lane_d.y   = lane_i.y + dy;
      lane_d.ang = lane_i.ang - Step;
    end
  end

  always_ff @(posedge clk_i) begin
    lane_o <= lane_d;
  end

endmodule
`default_nettype wire

@@ sv/quaternion_to_euler_angles_unit.sv @@
// throughput: one item every cycle, busy is never raised
// done_o marks each result once its start has passed through the pipeline of
// two front stages, 27 root cells, pre-rotation, 30 cordic cells and the output register
// reset clears only the valid chain; results are not held, receiver cannot stall
`default_nettype none
module quaternion_to_euler_angles_unit import q2e_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  output      logic               busy,
  input  wire logic signed [15:0] quat_x_i,
  input  wire logic signed [15:0] quat_y_i,
  input  wire logic signed [15:0] quat_z_i,
  input  wire logic signed [15:0] quat_w_i,
  output      logic               done_o,
  output      logic signed [15:0] roll_angle_o,
  output      logic signed [14:0] pitch_angle_o,
  output      logic signed [15:0] yaw_angle_o
);

  logic [Latency-1:0] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[Latency-2:0], start};
    end
  end

  assign busy   = 1'b0;
  assign done_o = vld_q[Latency-1];

  rot_ops_t   ops [0:SqrtCells];
  sqrt_lane_t sp  [0:SqrtCells];
  sqrt_lane_t cp  [0:SqrtCells];

  q2e_front u_front (
    .clk_i    (clk_i),
    .quat_x_i (quat_x_i),
    .quat_y_i (quat_y_i),
    .quat_z_i (quat_z_i),
    .quat_w_i (quat_w_i),
    .ops_o    (ops[0]),
    .sp_o     (sp[0]),
    .cp_o     (cp[0])
  );

  for (genvar k = 0; k < SqrtCells; k++) begin : g_sqrt
    q2e_sqrt_cell #(.Shift(SqrtCells - 1 - k)) u_sp (
      .clk_i  (clk_i),
      .lane_i (sp[k]),
      .lane_o (sp[k+1])
    );
    q2e_sqrt_cell #(.Shift(SqrtCells - 1 - k)) u_cp (
      .clk_i  (clk_i),
      .lane_i (cp[k]),
      .lane_o (cp[k+1])
    );
    // roll and yaw operands wait beside the root cells
    always_ff @(posedge clk_i) begin
      ops[k+1] <= ops[k];
    end
  end

  cordic_lane_t roll_l  [0:CordicCells];
  cordic_lane_t pitch_l [0:CordicCells];
  cordic_lane_t yaw_l   [0:CordicCells];

  logic signed [OpW-1:0] sp_op, cp_op;

  assign sp_op = {{(OpW-RootW){1'b0}}, sp[SqrtCells].res[RootW-1:0]};
  assign cp_op = {{(OpW-RootW){1'b0}}, cp[SqrtCells].res[RootW-1:0]};

  always_ff @(posedge clk_i) begin
    roll_l[0]  <= prerot(ops[SqrtCells].sr, ops[SqrtCells].cr);
    yaw_l[0]   <= prerot(ops[SqrtCells].sy, ops[SqrtCells].cy);
    pitch_l[0] <= prerot(sp_op, cp_op);
  end

  for (genvar i = 0; i < CordicCells; i++) begin : g_cordic
    q2e_cordic_cell #(.Iter(i)) u_roll (
      .clk_i  (clk_i),
      .lane_i (roll_l[i]),
      .lane_o (roll_l[i+1])
    );
    q2e_cordic_cell #(.Iter(i)) u_pitch (
      .clk_i  (clk_i),
      .lane_i (pitch_l[i]),
      .lane_o (pitch_l[i+1])
    );
    q2e_cordic_cell #(.Iter(i)) u_yaw (
      .clk_i  (clk_i),
      .lane_i (yaw_l[i]),
      .lane_o (yaw_l[i+1])
    );
  end

  cordic_lane_t rf, pf, yf;
  logic signed [35:0] roll_a, pitch_a, yaw_a;

  always_comb begin
    rf = roll_l[CordicCells];
    pf = pitch_l[CordicCells];
    yf = yaw_l[CordicCells];
    // both operands zero gives a zero angle
    roll_a  = rf.zero ? 36'sd0 : {{3{rf.ang[AngW-1]}}, rf.ang};
    yaw_a   = yf.zero ? 36'sd0 : {{3{yf.ang[AngW-1]}}, yf.ang};
    pitch_a = pf.zero ? 36'sd0 : {{3{pf.ang[AngW-1]}}, pf.ang};
    pitch_a = (pitch_a <<< 1) - {{3{HalfPi[AngW-1]}}, HalfPi};
  end

  logic signed [15:0] pitch_w;
  assign pitch_w = to_q13(pitch_a, PitchLim);

  always_ff @(posedge clk_i) begin
    roll_angle_o  <= to_q13(roll_a, RollLim);
    pitch_angle_o <= pitch_w[14:0];
    yaw_angle_o   <= to_q13(yaw_a, RollLim);
  end

endmodule
`default_nettype wire

@@ sv/q2e_checker.sv @@
`default_nettype none
module q2e_checker import q2e_pkg::*; (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               start,
  input wire logic               busy,
  input wire logic               done_o,
  input wire logic signed [15:0] roll_angle_o,
  input wire logic signed [14:0] pitch_angle_o,
  input wire logic signed [15:0] yaw_angle_o
);

  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni) !busy)
    else $error("busy raised");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##(Latency) done_o)
    else $error("item result missing");

  a_roll_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (roll_angle_o <= RollLim && roll_angle_o >= -RollLim &&
                yaw_angle_o <= RollLim && yaw_angle_o >= -RollLim))
    else $error("roll or yaw out of range");

  a_pitch_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ($signed({pitch_angle_o[14], pitch_angle_o}) <= PitchLim &&
                $signed({pitch_angle_o[14], pitch_angle_o}) >= -PitchLim))
    else $error("pitch out of range");

endmodule

bind quaternion_to_euler_angles_unit q2e_checker u_q2e_checker (.*);
`default_nettype wire
